// ===== src/zspd_pkg.sv =====
package zspd_pkg;

    // fixed field widths
    localparam int THR_W  = 4;
    localparam int INF_W  = 9;
    localparam int EPS_W  = 16;
    localparam int STD_W  = 24;
    localparam int FLAG_W = 2;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register map, index taken from paddr[3:2]
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_INFLUENCE = 2'd1;
    localparam logic [1:0] REG_EPSILON   = 2'd2;

    localparam logic [THR_W-1:0] THR_RESET = 4'd2;
    localparam logic [INF_W-1:0] INF_RESET = 9'd128;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd3;

    localparam logic [INF_W-1:0] INF_ONE     = 9'd256;
    localparam int               BLEND_ROUND = 128;
    localparam logic [STD_W-1:0] STD_MAX     = 24'h7FFFFF;

    // peak flag codes
    localparam logic [FLAG_W-1:0] PEAK_NONE = 2'b00;
    localparam logic [FLAG_W-1:0] PEAK_POS  = 2'b01;
    localparam logic [FLAG_W-1:0] PEAK_NEG  = 2'b11;

    typedef struct packed {
        logic [THR_W-1:0] threshold_mult;
        logic [INF_W-1:0] influence_q8;
        logic [EPS_W-1:0] epsilon_q8;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_FLAG,
        ST_SQUARE,
        ST_WRITE,
        ST_MEAN,
        ST_MUL,
        ST_VAR,
        ST_ROOT,
        ST_DONE
    } t_state;

endpackage

// ===== src/zspd_sample_if.sv =====
interface zspd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// ===== src/zspd_result_if.sv =====
interface zspd_result_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                                valid;
    logic                                ready;
    logic signed [zspd_pkg::FLAG_W-1:0]  peak_flag;
    logic signed [zspd_pkg::STD_W-1:0]   deviation_q8;
    logic signed [SAMPLE_BITS-1:0]       window_mean;

    modport source (output valid, output peak_flag, output deviation_q8,
                    output window_mean, input ready);
    modport sink (input valid, input peak_flag, input deviation_q8,
                  input window_mean, output ready);
endinterface

// ===== src/zspd_cfg_regs.sv =====
module zspd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zspd_pkg::APB_AW-1:0]   paddr,
    input  logic [zspd_pkg::APB_DW-1:0]   pwdata,
    output logic [zspd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output zspd_pkg::t_cfg                o_cfg
);

    zspd_pkg::t_cfg r_cfg;
    logic           w_write;
    logic [1:0]     w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_mult <= zspd_pkg::THR_RESET;
            r_cfg.influence_q8   <= zspd_pkg::INF_RESET;
            r_cfg.epsilon_q8     <= zspd_pkg::EPS_RESET;
        end else if (w_write) begin
            case (w_index)
                zspd_pkg::REG_THRESHOLD: begin
                    r_cfg.threshold_mult <= pwdata[zspd_pkg::THR_W-1:0];
                end
                zspd_pkg::REG_INFLUENCE: begin
                    r_cfg.influence_q8 <= pwdata[zspd_pkg::INF_W-1:0];
                end
                zspd_pkg::REG_EPSILON: begin
                    r_cfg.epsilon_q8 <= pwdata[zspd_pkg::EPS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            zspd_pkg::REG_THRESHOLD: prdata = zspd_pkg::APB_DW'(r_cfg.threshold_mult);
            zspd_pkg::REG_INFLUENCE: prdata = zspd_pkg::APB_DW'(r_cfg.influence_q8);
            zspd_pkg::REG_EPSILON:   prdata = zspd_pkg::APB_DW'(r_cfg.epsilon_q8);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== src/zspd_ring_mem.sv =====
module zspd_ring_mem #(
    parameter int WINDOW      = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [$clog2(WINDOW)-1:0]       i_rd_addr,
    output logic signed [SAMPLE_BITS-1:0]   o_rd_value,
    output logic [2*SAMPLE_BITS-2:0]        o_rd_square,
    input  logic                            i_wr_en,
    input  logic [$clog2(WINDOW)-1:0]       i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]   i_wr_value,
    input  logic [2*SAMPLE_BITS-2:0]        i_wr_square
);

    localparam int SQ_W = 2*SAMPLE_BITS-1;
    localparam int EW   = SAMPLE_BITS + SQ_W;

    logic [EW-1:0] r_mem [WINDOW];
    logic [EW-1:0] r_rd_word;
    logic          r_full;

    // slots are written in order from 1 up to 0, so until slot 0 has been
    // written every slot read is still untouched and reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_wr_en && (i_wr_addr == '0)) begin
            r_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_value, i_wr_square};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_value  = r_full ? r_rd_word[EW-1:SQ_W] : '0;
    assign o_rd_square = r_full ? r_rd_word[SQ_W-1:0] : '0;

endmodule

// ===== src/zspd_sqmul.sv =====
module zspd_sqmul #(
    parameter int OP_W = 21
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [OP_W-1:0] i_operand,
    output logic                   o_done,
    output logic [2*OP_W-1:0]      o_square
);

    localparam int ITER = (OP_W + 1) / 2;
    localparam int PW   = 2*OP_W;
    localparam int MW   = 2*ITER;
    localparam int CW   = (ITER > 1) ? $clog2(ITER) : 1;

    logic [OP_W-1:0] w_abs;
    logic [PW-1:0]   w_addend;
    logic [PW-1:0]   r_mcand;
    logic [PW-1:0]   r_mcand3;
    logic [MW-1:0]   r_mplier;
    logic [PW-1:0]   r_acc;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    assign w_abs = i_operand[OP_W-1] ? OP_W'(-i_operand) : OP_W'(i_operand);

    // two multiplier bits per step
    always_comb begin
        case (r_mplier[1:0])
            2'd1:    w_addend = r_mcand;
            2'd2:    w_addend = r_mcand << 1;
            2'd3:    w_addend = r_mcand3;
            default: w_addend = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ITER-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= PW'(w_abs);
            r_mcand3 <= PW'(w_abs) + (PW'(w_abs) << 1);
            r_mplier <= MW'(w_abs);
            r_acc    <= '0;
        end else if (r_busy) begin
            r_acc    <= r_acc + w_addend;
            r_mcand  <= r_mcand << 2;
            r_mcand3 <= r_mcand3 << 2;
            r_mplier <= r_mplier >> 2;
        end
    end

    assign o_done   = r_done;
    assign o_square = r_acc;

endmodule

// ===== src/zspd_isqrt.sv =====
module zspd_isqrt #(
    parameter int RAD_W = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [RAD_W-1:0]   i_radicand,
    output logic               o_done,
    output logic [RAD_W/2-1:0] o_root
);

    localparam int RW = RAD_W / 2;
    localparam int CW = $clog2(RW);

    logic [RAD_W-1:0] r_rad;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [RW+1:0]    w_rem_sh;
    logic [RW+1:0]    w_trial;
    logic             w_ge;

    // one root bit per cycle, restoring form
    assign w_rem_sh = {r_rem[RW-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== src/zscore_peak_detector.sv =====
// channel      dir  fields                                   transfer
// i_sample_ch  in   sample                                   valid && ready
// o_result_ch  out  peak_flag, deviation_q8, window_mean     valid && ready
// apb          in   threshold_mult, influence_q8, epsilon_q8 psel && penable && pwrite
//
// one sample at a time: the next is taken once the last result is in the output
// register; the work per sample is set by the 2-bit-per-cycle squarer of the
// running sum and the 1-bit-per-cycle square root of the variance; the ring is
// one read and one write of a window memory with separate read and write ports.
// WINDOW must be a power of two
// synchronous reset empties the window at once, no clearing pass
// a stalled result sits in the output register while the next sample is taken
module zscore_peak_detector #(
    parameter int WINDOW      = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    zspd_sample_if.sink                   i_sample_ch,
    zspd_result_if.source                 o_result_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zspd_pkg::APB_AW-1:0]   paddr,
    input  logic [zspd_pkg::APB_DW-1:0]   pwdata,
    output logic [zspd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int LW    = $clog2(WINDOW);
    localparam int SUMW  = SB + LW;
    localparam int SQEW  = 2*SB - 1;
    localparam int SQW   = SQEW + LW;
    localparam int PW    = 2*SUMW;
    localparam int NW    = SQW + LW;
    localparam int VW    = NW + 16 - 2*LW;
    localparam int SRW   = VW + 1;
    localparam int RW    = SRW / 2;
    localparam int BANDW = zspd_pkg::THR_W + zspd_pkg::STD_W;
    localparam int CMPW  = (SB + 9 > BANDW + 1) ? SB + 9 : BANDW + 1;
    localparam int BLW   = SB + 12;

    zspd_pkg::t_state r_state;
    zspd_pkg::t_state n_state;
    zspd_pkg::t_cfg   w_cfg;

    // window state
    logic signed [SUMW-1:0]   r_sum;
    logic [SQW-1:0]           r_sqsum;
    logic signed [SB-1:0]     r_mean;
    logic [zspd_pkg::STD_W-1:0] r_std;
    logic signed [SB-1:0]     r_last;
    logic [LW-1:0]            r_ptr;
    logic [LW-1:0]            w_nxt;

    // per-sample working registers
    logic signed [SB-1:0]     r_x;
    logic signed [SB+8:0]     r_dev;
    logic [BANDW-1:0]         r_band;
    logic signed [SB+10:0]    r_prod;
    logic [zspd_pkg::FLAG_W-1:0] r_flag;
    logic signed [SB-1:0]     r_stored;
    logic [SQEW-1:0]          r_square;
    logic [VW-1:0]            r_var;

    // result register
    logic                     r_out_valid;
    logic [zspd_pkg::FLAG_W-1:0] r_out_flag;
    logic [zspd_pkg::STD_W-1:0]  r_out_dev;
    logic signed [SB-1:0]     r_out_mean;

    // control
    logic w_accept;
    logic w_in_ready;
    logic w_rd_en;
    logic w_wr_en;
    logic w_mul_start;
    logic w_root_start;
    logic w_load_out;
    logic w_out_free;
    logic w_mul_done;
    logic w_root_done;

    // datapath
    logic signed [SB-1:0]     w_ring_value;
    logic [SQEW-1:0]          w_ring_square;
    logic signed [SB:0]       w_x_mean;
    logic signed [SB:0]       w_x_last;
    logic [zspd_pkg::INF_W-1:0] w_inf;
    logic signed [CMPW-1:0]   w_dev_ext;
    logic signed [CMPW-1:0]   w_band_ext;
    logic [zspd_pkg::FLAG_W-1:0] w_flag;
    logic signed [BLW-1:0]    w_last_sh;
    logic signed [BLW-1:0]    w_blend;
    logic signed [2*SB-1:0]   w_sq;
    logic [PW-1:0]            w_sum_sq;
    logic [NW-1:0]            w_wq;
    logic [NW-1:0]            w_n;
    logic [NW+15:0]           w_n_q16;
    logic [VW-1:0]            w_var;
    logic [RW-1:0]            w_root;
    logic [VW-1:0]            w_eps_q16;
    logic [zspd_pkg::STD_W-1:0] w_std_new;

    zspd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    zspd_ring_mem #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_rd_en),
        .i_rd_addr   (w_nxt),
        .o_rd_value  (w_ring_value),
        .o_rd_square (w_ring_square),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_nxt),
        .i_wr_value  (r_stored),
        .i_wr_square (r_square)
    );

    zspd_sqmul #(
        .OP_W (SUMW)
    ) u_sqmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_operand (r_sum),
        .o_done    (w_mul_done),
        .o_square  (w_sum_sq)
    );

    zspd_isqrt #(
        .RAD_W (SRW)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand ({1'b0, w_var}),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    assign w_nxt      = r_ptr + LW'(1);
    assign w_accept   = i_sample_ch.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_result_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zspd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_in_ready   = 1'b0;
        w_rd_en      = 1'b0;
        w_wr_en      = 1'b0;
        w_mul_start  = 1'b0;
        w_root_start = 1'b0;
        w_load_out   = 1'b0;
        case (r_state)
            zspd_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
                w_rd_en    = i_sample_ch.valid;
                if (i_sample_ch.valid) begin
                    n_state = zspd_pkg::ST_PREP;
                end
            end
            zspd_pkg::ST_PREP:   n_state = zspd_pkg::ST_FLAG;
            zspd_pkg::ST_FLAG:   n_state = zspd_pkg::ST_SQUARE;
            zspd_pkg::ST_SQUARE: n_state = zspd_pkg::ST_WRITE;
            zspd_pkg::ST_WRITE: begin
                w_wr_en = 1'b1;
                n_state = zspd_pkg::ST_MEAN;
            end
            zspd_pkg::ST_MEAN: begin
                w_mul_start = 1'b1;
                n_state     = zspd_pkg::ST_MUL;
            end
            zspd_pkg::ST_MUL: begin
                if (w_mul_done) begin
                    n_state = zspd_pkg::ST_VAR;
                end
            end
            zspd_pkg::ST_VAR: begin
                w_root_start = 1'b1;
                n_state      = zspd_pkg::ST_ROOT;
            end
            zspd_pkg::ST_ROOT: begin
                if (w_root_done) begin
                    n_state = zspd_pkg::ST_DONE;
                end
            end
            zspd_pkg::ST_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = zspd_pkg::ST_IDLE;
                end
            end
            default: n_state = zspd_pkg::ST_IDLE;
        endcase
    end

    // band test against the previous mean and std
    assign w_x_mean   = (SB+1)'(r_x) - (SB+1)'(r_mean);
    assign w_x_last   = (SB+1)'(r_x) - (SB+1)'(r_last);
    assign w_inf      = (w_cfg.influence_q8 > zspd_pkg::INF_ONE) ? zspd_pkg::INF_ONE
                                                                 : w_cfg.influence_q8;
    assign w_dev_ext  = CMPW'(r_dev);
    assign w_band_ext = signed'(CMPW'(r_band));

    always_comb begin
        if (w_dev_ext > w_band_ext) begin
            w_flag = zspd_pkg::PEAK_POS;
        end else if (w_dev_ext < -w_band_ext) begin
            w_flag = zspd_pkg::PEAK_NEG;
        end else begin
            w_flag = zspd_pkg::PEAK_NONE;
        end
    end

    // last*256 + inf*(x - last) + half, floored by the shift
    assign w_last_sh = {{4{r_last[SB-1]}}, r_last, 8'h00};
    assign w_blend   = w_last_sh + BLW'(r_prod) + BLW'(zspd_pkg::BLEND_ROUND);
    assign w_sq      = r_stored * r_stored;

    // W*var*W = W*sumsq - sum^2, scaled to Q.16
    assign w_wq    = {r_sqsum, {LW{1'b0}}};
    assign w_n     = w_wq - w_sum_sq[NW-1:0];
    assign w_n_q16 = {w_n, 16'h0000};
    assign w_var   = w_n_q16[NW+15:2*LW];

    assign w_eps_q16 = VW'({w_cfg.epsilon_q8, 8'h00});

    always_comb begin
        if (r_var < w_eps_q16) begin
            w_std_new = zspd_pkg::STD_W'(w_cfg.epsilon_q8);
        end else if (32'(w_root) > 32'(zspd_pkg::STD_MAX)) begin
            w_std_new = zspd_pkg::STD_MAX;
        end else begin
            w_std_new = zspd_pkg::STD_W'(w_root);
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sqsum <= '0;
            r_mean  <= '0;
            r_std   <= '0;
            r_last  <= '0;
            r_ptr   <= '0;
        end else begin
            case (r_state)
                zspd_pkg::ST_PREP: begin
                    // drop the value leaving the window
                    r_sum   <= r_sum - SUMW'(w_ring_value);
                    r_sqsum <= r_sqsum - SQW'(w_ring_square);
                end
                zspd_pkg::ST_WRITE: begin
                    r_sum   <= r_sum + SUMW'(r_stored);
                    r_sqsum <= r_sqsum + SQW'(r_square);
                    r_last  <= r_stored;
                    r_ptr   <= w_nxt;
                end
                zspd_pkg::ST_MEAN: begin
                    r_mean <= r_sum[SUMW-1:LW];
                end
                zspd_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_std <= w_std_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_sample_ch.sample;
        end
        case (r_state)
            zspd_pkg::ST_PREP: begin
                r_dev  <= {w_x_mean, 8'h00};
                r_band <= w_cfg.threshold_mult * r_std;
                r_prod <= $signed({1'b0, w_inf}) * w_x_last;
            end
            zspd_pkg::ST_FLAG: begin
                r_flag   <= w_flag;
                r_stored <= (w_flag != zspd_pkg::PEAK_NONE) ? w_blend[SB+7:8] : r_x;
            end
            zspd_pkg::ST_SQUARE: begin
                r_square <= w_sq[SQEW-1:0];
            end
            zspd_pkg::ST_VAR: begin
                r_var <= w_var;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_flag <= r_flag;
            r_out_dev  <= w_std_new;
            r_out_mean <= r_mean;
        end
    end

    assign i_sample_ch.ready        = w_in_ready;
    assign o_result_ch.valid        = r_out_valid;
    assign o_result_ch.peak_flag    = r_out_flag;
    assign o_result_ch.deviation_q8 = r_out_dev;
    assign o_result_ch.window_mean  = r_out_mean;

endmodule

// ===== src/zspd_checker.sv =====
module zspd_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [zspd_pkg::FLAG_W-1:0] i_out_flag,
    input logic [zspd_pkg::STD_W-1:0]  i_out_dev,
    input logic [SAMPLE_BITS-1:0]      i_out_mean
);

    // a result waiting for its transfer holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_flag)
            && $stable(i_out_dev) && $stable(i_out_mean))
        else $error("result changed while stalled");

    // one sample in flight: busy right after a transfer in
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while another is in work");

    // a result never appears in the cycle after a sample is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // flag is one of the three codes
    a_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_flag == zspd_pkg::PEAK_NONE)
            || (i_out_flag == zspd_pkg::PEAK_POS) || (i_out_flag == zspd_pkg::PEAK_NEG))
        else $error("bad peak flag");

    // the std or epsilon reported is never negative
    a_dev_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_dev[zspd_pkg::STD_W-1])
        else $error("negative deviation");

endmodule

bind zscore_peak_detector zspd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_zspd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample_ch.valid),
    .i_in_ready  (i_sample_ch.ready),
    .i_out_valid (o_result_ch.valid),
    .i_out_ready (o_result_ch.ready),
    .i_out_flag  (o_result_ch.peak_flag),
    .i_out_dev   (o_result_ch.deviation_q8),
    .i_out_mean  (o_result_ch.window_mean)
);
